// ===== rtl/core/sqdk_pkg.sv =====
// Shared types and constants for the squared-distance top-k search core.
// Used by every module under rtl/core; depends on nothing.
package sqdk_pkg;

  localparam int DIM       = 16;  // elements per vector
  localparam int ELEM_W    = 16;  // width of one int16 element
  localparam int WORD_W    = 64;  // width of one packed vector word
  localparam int NUM_WORDS = 4;   // packed words per vector
  localparam int ELEMS_PER_WORD = WORD_W / ELEM_W;
  localparam int GROUPS    = 4;   // partial sums in the first adder level
  localparam int GROUP_SZ  = DIM / GROUPS;
  localparam int DIST_W    = 32;
  localparam int ID_W      = 16;
  localparam int RANK_W    = 4;
  localparam int KEEP_W    = 5;
  localparam int K_MAX_DEF = 16;

  // APB register map: 64-bit registers at byte address 8*i.
  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 6;
  localparam int IDX_LSB   = 3;
  localparam int IDX_W     = ADDR_W - IDX_LSB;

  typedef enum logic [IDX_W-1:0] {
    REG_QUERY_W0   = 3'd0,
    REG_QUERY_W1   = 3'd1,
    REG_QUERY_W2   = 3'd2,
    REG_QUERY_W3   = 3'd3,
    REG_KEEP_COUNT = 3'd4
  } reg_idx_e;

  // Sideband that travels with a candidate down the pipeline.
  typedef struct packed {
    logic            vld;
    logic [ID_W-1:0] id;
    logic            last;
  } item_tag_t;

  // Status reported by the sorted list to the top-level control.
  typedef struct packed {
    logic rd_active;  // readout of the list in progress
    logic rd_done;    // final entry of the readout moves to the output register
  } list_status_t;

endpackage

// ===== rtl/core/sqdk_lane.sv =====
// One difference-square lane: wrapped int16 difference, squared, registered.
// Depends on sqdk_pkg.
module sqdk_lane (
  input  logic                         clk_i,
  input  logic [sqdk_pkg::ELEM_W-1:0]  q_elem_i,
  input  logic [sqdk_pkg::ELEM_W-1:0]  v_elem_i,
  output logic [sqdk_pkg::DIST_W-1:0]  sq_o
);
  import sqdk_pkg::*;

  logic signed [ELEM_W-1:0] diff;
  logic signed [DIST_W-1:0] sq_d;
  logic        [DIST_W-1:0] sq_q;

  // The difference wraps to 16 bits before it is squared.
  assign diff = $signed(q_elem_i - v_elem_i);
  assign sq_d = DIST_W'(diff) * DIST_W'(diff);

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign sq_o = sq_q;

endmodule

// ===== rtl/core/sqdk_merge.sv =====
// Two-level registered adder tree that merges the lane squares into one distance.
// Depends on sqdk_pkg.
module sqdk_merge (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [sqdk_pkg::DIST_W-1:0]    sq_i [sqdk_pkg::DIM],
  input  sqdk_pkg::item_tag_t            tag_i,
  output logic signed [sqdk_pkg::DIST_W-1:0] dist_o,
  output sqdk_pkg::item_tag_t            tag_o
);
  import sqdk_pkg::*;

  logic [DIST_W-1:0] part_d [GROUPS];
  logic [DIST_W-1:0] part_q [GROUPS];
  logic [DIST_W-1:0] dist_d;
  logic [DIST_W-1:0] dist_q;
  item_tag_t         tag_a_q;
  item_tag_t         tag_b_q;

  // Sums wrap modulo 2^32.
  always_comb begin
    for (int j = 0; j < GROUPS; j++) begin
      part_d[j] = '0;
      for (int e = 0; e < GROUP_SZ; e++) begin
        part_d[j] = part_d[j] + sq_i[j*GROUP_SZ + e];
      end
    end
  end

  always_comb begin
    dist_d = '0;
    for (int j = 0; j < GROUPS; j++) begin
      dist_d = dist_d + part_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    dist_q <= dist_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
    end
  end

  assign dist_o = $signed(dist_q);
  assign tag_o  = tag_b_q;

endmodule

// ===== rtl/core/sqdk_best_list.sv =====
// Sorted compare-and-shift list of the nearest candidates, with shift-out readout
// into the output register. Depends on sqdk_pkg.
module sqdk_best_list #(
  parameter int K_MAX = sqdk_pkg::K_MAX_DEF,
  localparam int KW   = $clog2(K_MAX + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [sqdk_pkg::DIST_W-1:0] dist_i,
  input  sqdk_pkg::item_tag_t                tag_i,
  input  logic [KW-1:0]                      k_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic signed [sqdk_pkg::DIST_W-1:0] distance_o,
  output logic [sqdk_pkg::ID_W-1:0]          result_id_o,
  output logic [sqdk_pkg::RANK_W-1:0]        rank_o,
  output logic                               last_result_o,
  output sqdk_pkg::list_status_t             status_o
);
  import sqdk_pkg::*;

  logic signed [DIST_W-1:0] dist_q [K_MAX];
  logic [ID_W-1:0]          id_q   [K_MAX];
  logic signed [DIST_W-1:0] prev_dist [K_MAX];
  logic [ID_W-1:0]          prev_id   [K_MAX];
  logic signed [DIST_W-1:0] next_dist [K_MAX];
  logic [ID_W-1:0]          next_id   [K_MAX];

  logic [KW-1:0] fill_q, fill_d, fill_eff, fill_ins;
  logic [KW-1:0] rd_cnt_q, rd_cnt_d, rd_n_q, rd_n_d;
  logic          rd_active_q, rd_active_d;
  logic          out_valid_q, out_valid_d;
  logic signed [DIST_W-1:0] out_dist_q;
  logic [ID_W-1:0]          out_id_q;
  logic [RANK_W-1:0]        out_rank_q;
  logic                     out_last_q;

  logic               ins_v;
  logic               ld_out;
  logic               rd_last;
  logic [K_MAX-1:0]   stay;      // entry keeps its place (valid and not farther)
  logic [K_MAX:0]     stay_ext;  // stay shifted up by one, entry zero sees a 1
  logic [K_MAX-1:0]   in_k;      // entry index lies below the keep count

  assign ins_v    = tag_i.vld;
  // A lowered keep count cuts the list before the insert.
  assign fill_eff = (fill_q > k_i) ? k_i : fill_q;
  assign fill_ins = (fill_eff < k_i) ? fill_eff + 1'b1 : k_i;

  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      in_k[i] = KW'(i) < k_i;
      stay[i] = (KW'(i) < fill_eff) && !(dist_q[i] > dist_i);
    end
  end
  assign stay_ext = {stay, 1'b1};

  for (genvar g = 0; g < K_MAX; g++) begin : g_entry
    if (g == 0) begin : g_head
      assign prev_dist[g] = dist_i;
      assign prev_id[g]   = tag_i.id;
    end else begin : g_body
      assign prev_dist[g] = dist_q[g-1];
      assign prev_id[g]   = id_q[g-1];
    end
    if (g == K_MAX - 1) begin : g_tail
      assign next_dist[g] = dist_q[g];
      assign next_id[g]   = id_q[g];
    end else begin : g_inner
      assign next_dist[g] = dist_q[g+1];
      assign next_id[g]   = id_q[g+1];
    end

    // The new candidate lands at the first entry that is farther away or empty; the
    // entries behind it move down by one place. A rejected candidate finds no
    // such entry below the keep count.
    always_ff @(posedge clk_i) begin
      if (ld_out) begin
        dist_q[g] <= next_dist[g];
        id_q[g]   <= next_id[g];
      end else if (ins_v && !stay[g] && in_k[g]) begin
        if (stay_ext[g]) begin
          dist_q[g] <= dist_i;
          id_q[g]   <= tag_i.id;
        end else begin
          dist_q[g] <= prev_dist[g];
          id_q[g]   <= prev_id[g];
        end
      end
    end
  end

  // Readout shifts the list toward the head, one entry per output transfer.
  assign ld_out  = rd_active_q && (!out_valid_q || out_ready_i);
  assign rd_last = (rd_cnt_q == rd_n_q - 1'b1);

  always_comb begin
    fill_d      = fill_q;
    rd_active_d = rd_active_q;
    rd_cnt_d    = rd_cnt_q;
    rd_n_d      = rd_n_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ins_v) begin
      fill_d = fill_ins;
      if (tag_i.last) begin
        rd_active_d = 1'b1;
        rd_cnt_d    = '0;
        rd_n_d      = fill_ins;
      end
    end
    if (ld_out) begin
      out_valid_d = 1'b1;
      rd_cnt_d    = rd_cnt_q + 1'b1;
      if (rd_last) begin
        rd_active_d = 1'b0;
        fill_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      rd_active_q <= 1'b0;
      rd_cnt_q    <= '0;
      rd_n_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      rd_active_q <= rd_active_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_n_q      <= rd_n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      out_dist_q <= dist_q[0];
      out_id_q   <= id_q[0];
      out_rank_q <= RANK_W'(rd_cnt_q);
      out_last_q <= rd_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign distance_o       = out_dist_q;
  assign result_id_o      = out_id_q;
  assign rank_o           = out_rank_q;
  assign last_result_o    = out_last_q;
  assign status_o.rd_active = rd_active_q;
  assign status_o.rd_done   = ld_out && rd_last;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= KW'(K_MAX))
    else $error("fill count beyond list depth");

  a_no_insert_in_readout : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ins_v && rd_active_q))
    else $error("candidate inserted during readout");

  a_readout_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_active_q |-> (rd_n_q != '0) && (rd_cnt_q < rd_n_q))
    else $error("readout counter outside the list");

endmodule

// ===== rtl/core/sq_distance_topk_select_core.sv =====
// Top level of the squared-distance top-k search core: APB registers, sixteen
// difference-square lanes, the merging adder tree and the sorted list.
// Depends on sqdk_pkg, sqdk_lane, sqdk_merge and sqdk_best_list.
//
//   Channel   Handshake              Payload
//   -------   --------------------   ------------------------------------------
//   in        in_valid_i/in_ready_o  vec_w0_i..vec_w3_i, item_id_i, last_item_i
//   out       out_valid_o/out_ready_i distance_o, result_id_o, rank_o,
//                                     last_result_o
//   config    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// A candidate is taken every clock while a search collects. The transfer edge
// loads the lane square registers, the two adder tree levels follow, and the
// compare-and-shift insert comes after the second level. A transfer with
// last_item_i set closes the input until the whole list has moved into the
// output register; a stall on out_ready_i holds that readout back.
// The output register lets a new search start while the final result waits.
// Reset clears the control state, the fill count and the registers to their
// defaults; the list entries themselves need no clearing.
module sq_distance_topk_select_core #(
  parameter int K_MAX = sqdk_pkg::K_MAX_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sqdk_pkg::ADDR_W-1:0]        paddr,
  input  logic [sqdk_pkg::DATA_W-1:0]        pwdata,
  output logic [sqdk_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  // Candidate input
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sqdk_pkg::WORD_W-1:0]        vec_w0_i,
  input  logic [sqdk_pkg::WORD_W-1:0]        vec_w1_i,
  input  logic [sqdk_pkg::WORD_W-1:0]        vec_w2_i,
  input  logic [sqdk_pkg::WORD_W-1:0]        vec_w3_i,
  input  logic [sqdk_pkg::ID_W-1:0]          item_id_i,
  input  logic                               last_item_i,
  // Result output
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [sqdk_pkg::DIST_W-1:0] distance_o,
  output logic [sqdk_pkg::ID_W-1:0]          result_id_o,
  output logic [sqdk_pkg::RANK_W-1:0]        rank_o,
  output logic                               last_result_o
);
  import sqdk_pkg::*;

  localparam int KW = $clog2(K_MAX + 1);
  // Common width for comparing the keep count register against K_MAX.
  localparam int CW = (KW > KEEP_W) ? KW : KEEP_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Address bits below IDX_LSB are ignored.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] query_q [NUM_WORDS];
  logic [KEEP_W-1:0] keep_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:IDX_LSB]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        query_q[w] <= '0;
      end
      keep_q <= KEEP_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_QUERY_W0:   query_q[0] <= pwdata;
        REG_QUERY_W1:   query_q[1] <= pwdata;
        REG_QUERY_W2:   query_q[2] <= pwdata;
        REG_QUERY_W3:   query_q[3] <= pwdata;
        REG_KEEP_COUNT: keep_q     <= pwdata[KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_QUERY_W0:   prdata = query_q[0];
      REG_QUERY_W1:   prdata = query_q[1];
      REG_QUERY_W2:   prdata = query_q[2];
      REG_QUERY_W3:   prdata = query_q[3];
      REG_KEEP_COUNT: prdata = DATA_W'(keep_q);
      default:        prdata = '0;
    endcase
  end

  // A keep count of zero acts as one, and anything above the list depth is
  // clamped to the depth.
  logic [CW-1:0] keep_ext;
  logic [KW-1:0] k_eff;

  assign keep_ext = CW'(keep_q);
  always_comb begin
    if (keep_ext == '0) begin
      k_eff = KW'(1);
    end else if (keep_ext > CW'(K_MAX)) begin
      k_eff = KW'(K_MAX);
    end else begin
      k_eff = KW'(keep_ext);
    end
  end

  // ---------------------------------------------------------------------------
  // Input control. The input closes from the transfer of a last item until the
  // list has been fully handed to the output register, so no candidate of the
  // next search can slip in ahead of the readout.
  // ---------------------------------------------------------------------------
  logic         busy_q, busy_d;
  logic         in_xfer;
  list_status_t status;

  assign in_ready_o = !busy_q;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    if (in_xfer && last_item_i) begin
      busy_d = 1'b1;
    end else if (status.rd_done) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Difference-square lanes, one per element. Their registers form stage one;
  // the tag register below travels alongside.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] vec_w [NUM_WORDS];
  logic [DIST_W-1:0] lane_sq [DIM];
  item_tag_t         tag1_q;

  assign vec_w[0] = vec_w0_i;
  assign vec_w[1] = vec_w1_i;
  assign vec_w[2] = vec_w2_i;
  assign vec_w[3] = vec_w3_i;

  for (genvar e = 0; e < DIM; e++) begin : g_lane
    sqdk_lane u_lane (
      .clk_i    (clk_i),
      .q_elem_i (query_q[e / ELEMS_PER_WORD][(e % ELEMS_PER_WORD)*ELEM_W +: ELEM_W]),
      .v_elem_i (vec_w[e / ELEMS_PER_WORD][(e % ELEMS_PER_WORD)*ELEM_W +: ELEM_W]),
      .sq_o     (lane_sq[e])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
    end else begin
      tag1_q.vld  <= in_xfer;
      tag1_q.id   <= item_id_i;
      tag1_q.last <= last_item_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Merge of the lane squares into one wrapped 32-bit distance.
  // ---------------------------------------------------------------------------
  logic signed [DIST_W-1:0] merge_dist;
  item_tag_t                merge_tag;

  sqdk_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sq_i   (lane_sq),
    .tag_i  (tag1_q),
    .dist_o (merge_dist),
    .tag_o  (merge_tag)
  );

  // ---------------------------------------------------------------------------
  // Sorted list and readout into the output register.
  // ---------------------------------------------------------------------------
  sqdk_best_list #(
    .K_MAX (K_MAX)
  ) u_best_list (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dist_i        (merge_dist),
    .tag_i         (merge_tag),
    .k_i           (k_eff),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .distance_o    (distance_o),
    .result_id_o   (result_id_o),
    .rank_o        (rank_o),
    .last_result_o (last_result_o),
    .status_o      (status)
  );

  a_readout_closes_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.rd_active |-> busy_q)
    else $error("readout running while the input is open");

  a_last_closes_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && last_item_i) |=> !in_ready_o)
    else $error("input still open after a last item");

  a_done_ends_readout : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.rd_done |=> !status.rd_active)
    else $error("readout continues after its final entry");

endmodule

// ===== tb/sq_distance_topk_select_core_tb.sv =====
// Self-checking testbench for sq_distance_topk_select_core: a scoreboard class
// predicts the ranked nearest list of each search and checks every result transfer.
// Depends on sqdk_pkg and the RTL of the core only.
`timescale 1ns / 1ps

module sq_distance_topk_select_core_tb;
  import sqdk_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int QUIET_CYCLES     = 24;   // pipeline depth plus a full readout, with margin
  localparam int TAIL_CYCLES      = 40;
  localparam int LIST_DEPTH       = K_MAX_DEF;
  localparam int VEC_W            = NUM_WORDS * WORD_W;
  localparam int ITEMS_PER_PHASE  = 100;
  localparam int PRINT_CAP        = 64;   // later mismatches are still counted

  typedef logic [VEC_W-1:0] vec_t;

  // One expected result transfer of a readout.
  typedef struct {
    logic signed [DIST_W-1:0] sq_sum;
    logic [ID_W-1:0]          id;
    logic [RANK_W-1:0]        rank;
    logic                     last;
  } ranked_t;

  localparam vec_t ALL_ZERO = '0;
  localparam vec_t ALL_MAX  = {DIM{16'h7FFF}};
  localparam vec_t ALL_MIN  = {DIM{16'h8000}};
  localparam vec_t ALL_NEG1 = {DIM{16'hFFFF}};

  // Tracks the query, keep count and sorted nearest list, and holds the ranked
  // results that each closed search is expected to produce.
  class topk_tracker;
    vec_t              query_bits;
    logic [KEEP_W-1:0] keep_reg;
    int                best_dist [LIST_DEPTH];
    logic [ID_W-1:0]   best_id [LIST_DEPTH];
    int                held;
    ranked_t           awaiting [$];
    int                mismatches;
    int                compared;
    int                candidates;
    int                searches;

    function new();
      query_bits = '0;
      keep_reg   = KEEP_W'(1);
      held       = 0;
      mismatches = 0;
      compared   = 0;
      candidates = 0;
      searches   = 0;
    endfunction

    function void write_register(reg_idx_e idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_QUERY_W0:   query_bits[0*WORD_W +: WORD_W] = value;
        REG_QUERY_W1:   query_bits[1*WORD_W +: WORD_W] = value;
        REG_QUERY_W2:   query_bits[2*WORD_W +: WORD_W] = value;
        REG_QUERY_W3:   query_bits[3*WORD_W +: WORD_W] = value;
        REG_KEEP_COUNT: keep_reg = value[KEEP_W-1:0];
        default: ;
      endcase
    endfunction

    // Lane differences wrap to 16 bits; the sum of squares wraps to 32 bits.
    function int sq_distance_of(vec_t cand);
      logic signed [ELEM_W-1:0] diff;
      int sq;
      int acc;
      acc = 0;
      for (int e = 0; e < DIM; e++) begin
        diff = query_bits[e*ELEM_W +: ELEM_W] - cand[e*ELEM_W +: ELEM_W];
        sq   = diff * diff;
        acc  = acc + sq;
      end
      return acc;
    endfunction

    function void note_candidate(vec_t cand, logic [ID_W-1:0] id, logic last);
      int k;
      int cand_sq;
      int pos;
      k = keep_reg;
      if (k == 0) k = 1;
      if (k > LIST_DEPTH) k = LIST_DEPTH;
      cand_sq = sq_distance_of(cand);
      candidates++;
      // A lowered keep count cuts the list before the next insert.
      if (held > k) held = k;
      if (!(held == k && cand_sq >= best_dist[k-1])) begin
        if (held < k) begin
          pos = held;
          held++;
        end else begin
          pos = k - 1;
        end
        // Strict compare: an equal distance stays behind earlier arrivals.
        while (pos > 0 && best_dist[pos-1] > cand_sq) begin
          best_dist[pos] = best_dist[pos-1];
          best_id[pos]   = best_id[pos-1];
          pos--;
        end
        best_dist[pos] = cand_sq;
        best_id[pos]   = id;
      end
      if (last) begin
        for (int i = 0; i < held; i++) begin
          awaiting.insert(awaiting.size(),
                          ranked_t'{sq_sum: best_dist[i], id: best_id[i],
                                    rank: RANK_W'(i), last: (i == held - 1)});
        end
        held = 0;
        searches++;
      end
    endfunction

    task report_mismatch(string what);
      if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_ranked(logic signed [DIST_W-1:0] got_sq, logic [ID_W-1:0] id,
                      logic [RANK_W-1:0] rank, logic last);
      ranked_t exp;
      if (awaiting.size() == 0) begin
        report_mismatch($sformatf("unexpected result id %h rank %0d", id, rank));
        return;
      end
      exp = awaiting.pop_front();
      compared++;
      if (got_sq !== exp.sq_sum)
        report_mismatch($sformatf("rank %0d distance %0d, expected %0d",
                                  exp.rank, got_sq, exp.sq_sum));
      if (id !== exp.id)
        report_mismatch($sformatf("rank %0d id %h, expected %h", exp.rank, id, exp.id));
      if (rank !== exp.rank)
        report_mismatch($sformatf("rank %0d, expected %0d", rank, exp.rank));
      if (last !== exp.last)
        report_mismatch($sformatf("rank %0d last flag %b, expected %b",
                                  exp.rank, last, exp.last));
    endtask
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [WORD_W-1:0]        vec_w0_i;
  logic [WORD_W-1:0]        vec_w1_i;
  logic [WORD_W-1:0]        vec_w2_i;
  logic [WORD_W-1:0]        vec_w3_i;
  logic [ID_W-1:0]          item_id_i;
  logic                     last_item_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DIST_W-1:0] distance_o;
  logic [ID_W-1:0]          result_id_o;
  logic [RANK_W-1:0]        rank_o;
  logic                     last_result_o;

  topk_tracker tracker;
  vec_t        cur_query;      // query as last written, used to aim candidates near it
  vec_t        recent [$];     // recent candidates, replayed to force equal distances
  int          in_idle_pct;
  int          out_idle_pct;
  int          cycle_count;

  sq_distance_topk_select_core #(
    .K_MAX(K_MAX_DEF)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .vec_w0_i     (vec_w0_i),
    .vec_w1_i     (vec_w1_i),
    .vec_w2_i     (vec_w2_i),
    .vec_w3_i     (vec_w3_i),
    .item_id_i    (item_id_i),
    .last_item_i  (last_item_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .distance_o   (distance_o),
    .result_id_o  (result_id_o),
    .rank_o       (rank_o),
    .last_result_o(last_result_o)
  );

  // 4 ns clock period.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // The receiver decides at each falling edge whether to take a result at the
  // next rising edge; the idle share is set per phase.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Every result transfer is checked against the oldest expected entry.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_ranked(distance_o, result_id_o, rank_o, last_result_o);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run timed out after %0d cycles with %0d results outstanding.",
             cycle_count, tracker.awaiting.size());
    $display("sq_distance_topk_select_core regression: fail");
    $finish;
  end

  // While valid is low the payload carries noise, which the core must ignore.
  task automatic drive_noise();
    vec_w0_i    <= {$urandom, $urandom};
    vec_w1_i    <= {$urandom, $urandom};
    vec_w2_i    <= {$urandom, $urandom};
    vec_w3_i    <= {$urandom, $urandom};
    item_id_i   <= ID_W'($urandom);
    last_item_i <= 1'($urandom);
  endtask

  // Presents one candidate and returns at the rising edge of its transfer.
  // Valid is left high, so the caller follows with another candidate or a stop.
  task automatic send_candidate(vec_t vec, logic [ID_W-1:0] id, logic last);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      drive_noise();
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    vec_w0_i    <= vec[0*WORD_W +: WORD_W];
    vec_w1_i    <= vec[1*WORD_W +: WORD_W];
    vec_w2_i    <= vec[2*WORD_W +: WORD_W];
    vec_w3_i    <= vec[3*WORD_W +: WORD_W];
    item_id_i   <= id;
    last_item_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_candidate(vec, id, last);
  endtask

  task automatic stop_candidates();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drive_noise();
  endtask

  // The core is idle once every expected result has been taken and any
  // trailing candidates without a readout have left the pipeline.
  task automatic wait_quiet();
    while (tracker.awaiting.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the value at
  // the rising edge where the access phase meets pready.
  task automatic apb_write(reg_idx_e idx, logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {IDX_LSB{1'b0}}};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.write_register(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_query(vec_t q);
    apb_write(REG_QUERY_W0, q[0*WORD_W +: WORD_W]);
    apb_write(REG_QUERY_W1, q[1*WORD_W +: WORD_W]);
    apb_write(REG_QUERY_W2, q[2*WORD_W +: WORD_W]);
    apb_write(REG_QUERY_W3, q[3*WORD_W +: WORD_W]);
    cur_query = q;
  endtask

  task automatic write_keep(int k);
    apb_write(REG_KEEP_COUNT, DATA_W'(k));
  endtask

  function automatic logic [ELEM_W-1:0] extreme_lane();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return 16'hFFFF;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Candidates mix lanes close to the query (small, dense distances), replays
  // of recent vectors (equal distances), plain noise and extreme lanes that
  // push the 32-bit sum past its wrap point.
  function automatic vec_t make_candidate();
    vec_t v;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      for (int e = 0; e < DIM; e++)
        v[e*ELEM_W +: ELEM_W] = cur_query[e*ELEM_W +: ELEM_W]
                              + ELEM_W'($urandom_range(0, 6)) - 16'd3;
    end else if (pick < 50 && recent.size() > 0) begin
      v = recent[$urandom_range(0, recent.size() - 1)];
    end else if (pick < 85) begin
      for (int e = 0; e < DIM; e++) v[e*ELEM_W +: ELEM_W] = ELEM_W'($urandom);
    end else begin
      for (int e = 0; e < DIM; e++) v[e*ELEM_W +: ELEM_W] = extreme_lane();
    end
    recent.insert(recent.size(), v);
    if (recent.size() > 8) void'(recent.pop_front());
    return v;
  endfunction

  function automatic vec_t random_query();
    vec_t q;
    case ($urandom_range(0, 3))
      0: for (int e = 0; e < DIM; e++) q[e*ELEM_W +: ELEM_W] = ELEM_W'($urandom);
      1: for (int e = 0; e < DIM; e++)
           q[e*ELEM_W +: ELEM_W] = ELEM_W'($urandom_range(0, 400)) - 16'd200;
      2: for (int e = 0; e < DIM; e++) q[e*ELEM_W +: ELEM_W] = extreme_lane();
      default: q = '0;
    endcase
    return q;
  endfunction

  // Zero and values above the list depth are legal register contents.
  function automatic int pick_keep();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return LIST_DEPTH;
      3:       return $urandom_range(LIST_DEPTH + 1, 31);
      default: return $urandom_range(2, LIST_DEPTH - 1);
    endcase
  endfunction

  // Mostly short searches, a few long enough to fill and churn a deep list.
  function automatic int search_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 12);
    if (pick < 95) return $urandom_range(13, 24);
    return $urandom_range(25, 40);
  endfunction

  task automatic run_search(int len, logic close);
    for (int i = 0; i < len; i++)
      send_candidate(make_candidate(), ID_W'($urandom), close && (i == len - 1));
  endtask

  // One idle profile. Between groups of searches the core is drained and
  // reconfigured; now and then a search is left open so that the next keep
  // count lands in the middle of it.
  task automatic run_phase(int in_pct, int out_pct, int budget);
    int sent;
    int n_searches;
    int len;
    logic leave_open;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    sent = 0;
    while (sent < budget) begin
      stop_candidates();
      wait_quiet();
      if ($urandom_range(0, 9) < 7) write_query(random_query());
      write_keep(pick_keep());
      n_searches = $urandom_range(1, 3);
      for (int s = 0; s < n_searches; s++) begin
        len = search_length();
        leave_open = (s == n_searches - 1) && ($urandom_range(0, 4) == 0);
        run_search(len, !leave_open);
        sent += len;
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    vec_w0_i     = '0;
    vec_w1_i     = '0;
    vec_w2_i     = '0;
    vec_w3_i     = '0;
    item_id_i    = '0;
    last_item_i  = 1'b0;
    out_ready_i  = 1'b0;
    in_idle_pct  = 12;
    out_idle_pct = 64;
    cur_query    = '0;
    tracker      = new();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: zero query and a single kept entry.
    send_candidate(ALL_MAX, 16'h0001, 1'b0);
    send_candidate(ALL_ZERO, 16'hFFFF, 1'b1);

    // Extreme lanes against an all-minimum query: one distance wraps negative,
    // two wrap to zero and tie, and the final candidate lies beyond the worst entry
    // of a full list and must be rejected.
    stop_candidates();
    wait_quiet();
    write_query(ALL_MIN);
    write_keep(4);
    send_candidate(ALL_MAX,  16'h0001, 1'b0);
    send_candidate(ALL_ZERO, 16'h0002, 1'b0);
    send_candidate(ALL_MIN,  16'h0003, 1'b0);
    send_candidate(ALL_NEG1, 16'h0004, 1'b0);
    send_candidate(ALL_ZERO, 16'h0005, 1'b0);
    send_candidate(ALL_MAX,  16'h0006, 1'b1);

    // Keep count lowered in the middle of a search: the list is cut before
    // the next candidate goes in.
    stop_candidates();
    wait_quiet();
    write_query({DIM/4{16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF}});
    write_keep(8);
    run_search(6, 1'b0);
    stop_candidates();
    wait_quiet();
    write_keep(2);
    run_search(2, 1'b1);

    // A keep count of zero acts as one.
    stop_candidates();
    wait_quiet();
    write_keep(0);
    run_search(3, 1'b1);

    // The largest register value saturates to the list depth; a one-candidate
    // search follows directly by another.
    stop_candidates();
    wait_quiet();
    write_keep(31);
    run_search(1, 1'b1);
    run_search(3, 1'b1);

    run_phase(12, 64, ITEMS_PER_PHASE);
    run_phase(64, 12, ITEMS_PER_PHASE);
    run_phase(0, 0, ITEMS_PER_PHASE);
    // Closes a search the last phase may have left open.
    run_search(1, 1'b1);
    stop_candidates();

    while (tracker.awaiting.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d candidates in %0d searches, %0d ranked results compared,",
             tracker.candidates, tracker.searches, tracker.compared);
    $display("under sender-heavy, receiver-heavy and unthrottled flow; %0d mismatches.",
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.awaiting.size() == 0) begin
      $display("sq_distance_topk_select_core regression: pass");
    end else begin
      $display("sq_distance_topk_select_core regression: fail");
    end
    $finish;
  end

endmodule
